/* hdl/edrt_pkg.sv */
// Shared constants and types for the expiring dirty-rectangle tracker.
package edrt_pkg;

	localparam int SLOT_COUNT = 8;
	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_SNAP  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// one table entry: rectangle edges plus expiry tick
	typedef struct packed {
		logic signed [63:0] expiry;
		logic signed [31:0] bottom;
		logic signed [31:0] right;
		logic signed [31:0] top;
		logic signed [31:0] left;
	} slot_t;

	typedef struct packed {
		logic signed [31:0] bottom;
		logic signed [31:0] right;
		logic signed [31:0] top;
		logic signed [31:0] left;
		logic               has_active;
		logic               expired_any;
	} result_t;

	// engine -> store request bundle
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		slot_t            wr_data;
		logic             clr_all;
		logic             drop_en;
		logic [IDX_W-1:0] drop_addr;
	} mem_req_t;

endpackage

/* hdl/edrt_store.sv */
// Slot memory (registered synchronous read) and per-slot active flags.
module edrt_store (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  edrt_pkg::mem_req_t                   req,
	output edrt_pkg::slot_t                      rd_data,
	output logic [edrt_pkg::SLOT_COUNT-1:0]      act
);
	import edrt_pkg::*;

	slot_t                 mem [SLOT_COUNT];
	slot_t                 rd_data_q;
	logic [SLOT_COUNT-1:0] act_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	// contents of an inactive slot are never used, so only the flags clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= '0;
		end else if (req.clr_all) begin
			act_q <= '0;
		end else begin
			if (req.wr_en) begin
				act_q[req.wr_addr] <= 1'b1;
			end
			if (req.drop_en) begin
				act_q[req.drop_addr] <= 1'b0;
			end
		end
	end

	assign rd_data = rd_data_q;
	assign act     = act_q;

endmodule

/* hdl/edrt_engine.sv */
// Command sequencer: decode, slot scan, merge write-back, result build.
module edrt_engine (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           cmd,
	input  edrt_pkg::slot_t                      cmd_slot,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output edrt_pkg::result_t                    res,
	output edrt_pkg::mem_req_t                   req,
	input  edrt_pkg::slot_t                      rd_data,
	input  logic [edrt_pkg::SLOT_COUNT-1:0]      act
);
	import edrt_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECODE = 5'b00010,
		S_SCAN   = 5'b00100,
		S_MERGE  = 5'b01000,
		S_EMIT   = 5'b10000
	} state_t;

	state_t           state_q;
	logic [1:0]       cmd_q;
	slot_t            cmd_slot_q;
	slot_t            best_q;
	logic [IDX_W-1:0] best_idx_q;
	result_t          res_q;
	logic [IDX_W-1:0] issue_idx_q;
	logic             issue_done_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	logic             add_ok;
	logic             free_hit;
	logic [IDX_W-1:0] free_idx;
	logic             best_empty;
	slot_t            merged;
	logic             slot_expired;

	always_comb begin
		add_ok = (cmd_q == CMD_ADD) && (cmd_slot_q.left < cmd_slot_q.right) &&
			(cmd_slot_q.top < cmd_slot_q.bottom) && (cmd_slot_q.expiry > 64'sd0);
		free_hit = 1'b0;
		free_idx = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (!free_hit && !act[i]) begin
				free_hit = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	// bounding-box union into the earliest-expiring slot
	always_comb begin
		best_empty = (best_q.left >= best_q.right) || (best_q.top >= best_q.bottom);
		merged     = best_q;
		if (best_empty) begin
			merged.left   = cmd_slot_q.left;
			merged.top    = cmd_slot_q.top;
			merged.right  = cmd_slot_q.right;
			merged.bottom = cmd_slot_q.bottom;
		end else begin
			if (cmd_slot_q.left < best_q.left)     merged.left   = cmd_slot_q.left;
			if (cmd_slot_q.top < best_q.top)       merged.top    = cmd_slot_q.top;
			if (cmd_slot_q.right > best_q.right)   merged.right  = cmd_slot_q.right;
			if (cmd_slot_q.bottom > best_q.bottom) merged.bottom = cmd_slot_q.bottom;
		end
		if (cmd_slot_q.expiry > best_q.expiry) begin
			merged.expiry = cmd_slot_q.expiry;
		end
	end

	assign slot_expired = rd_data.expiry <= cmd_slot_q.expiry;

	always_comb begin
		req           = '0;
		req.rd_en     = (state_q == S_SCAN) && !issue_done_q;
		req.rd_addr   = issue_idx_q;
		req.drop_addr = rd_idx_s1;
		case (state_q)
			S_DECODE: begin
				if (add_ok && free_hit) begin
					req.wr_en   = 1'b1;
					req.wr_addr = free_idx;
					req.wr_data = cmd_slot_q;
				end
				req.clr_all = (cmd_q == CMD_CLEAR);
			end
			S_SCAN: begin
				req.drop_en = rd_vld_s1 && (cmd_q == CMD_SNAP) && act[rd_idx_s1] &&
					slot_expired;
			end
			S_MERGE: begin
				req.wr_en   = 1'b1;
				req.wr_addr = best_idx_q;
				req.wr_data = merged;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			issue_done_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
		end else begin
			rd_vld_s1 <= req.rd_en;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					issue_done_q <= 1'b0;
					if ((add_ok && !free_hit) || (cmd_q == CMD_SNAP)) begin
						state_q <= S_SCAN;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_SCAN: begin
					if (req.rd_en && (issue_idx_q == LAST_IDX)) begin
						issue_done_q <= 1'b1;
					end
					if (rd_vld_s1 && (rd_idx_s1 == LAST_IDX)) begin
						state_q <= (cmd_q == CMD_SNAP) ? S_EMIT : S_MERGE;
					end
				end
				S_MERGE: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= issue_idx_q;
		if (state_q == S_IDLE && in_valid) begin
			cmd_q      <= cmd;
			cmd_slot_q <= cmd_slot;
			res_q      <= '0;
		end
		if (state_q == S_DECODE) begin
			issue_idx_q <= '0;
		end else if (req.rd_en && (issue_idx_q != LAST_IDX)) begin
			issue_idx_q <= issue_idx_q + 1'b1;
		end
		if (state_q == S_SCAN && rd_vld_s1) begin
			if (cmd_q == CMD_SNAP) begin
				if (act[rd_idx_s1]) begin
					if (slot_expired) begin
						res_q.expired_any <= 1'b1;
					end else if (!res_q.has_active) begin
						res_q.has_active <= 1'b1;
						res_q.left       <= rd_data.left;
						res_q.top        <= rd_data.top;
						res_q.right      <= rd_data.right;
						res_q.bottom     <= rd_data.bottom;
					end else begin
						if (rd_data.left < res_q.left)     res_q.left   <= rd_data.left;
						if (rd_data.top < res_q.top)       res_q.top    <= rd_data.top;
						if (rd_data.right > res_q.right)   res_q.right  <= rd_data.right;
						if (rd_data.bottom > res_q.bottom) res_q.bottom <= rd_data.bottom;
					end
				end
			end else if ((rd_idx_s1 == '0) || (rd_data.expiry < best_q.expiry)) begin
				best_q     <= rd_data;
				best_idx_q <= rd_idx_s1;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_EMIT);
	assign res       = res_q;

	a_no_read_outside_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == S_SCAN))
		else $error("read data returned outside a scan");
	a_merge_all_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MERGE) |-> (&act))
		else $error("merge with a free slot present");
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		req.clr_all |=> (act == '0))
		else $error("slots still active after clear");
	a_no_write_on_clear: assert property (@(posedge clk) disable iff (!arst_n)
		req.clr_all |-> !req.wr_en)
		else $error("write coincides with clear");

endmodule

/* hdl/expiring_dirty_rect_tracker.sv */
// Top level of the expiring dirty-rectangle tracker: stream ports and result register.
//
// Input channel s_*: one transaction is one command. s_tuser carries cmd
// (add, snapshot, clear); s_tdata carries the rectangle and the time stamp
// (expiry tick for add, current tick for snapshot).
// Output channel m_*: exactly one result transaction per command. Add, clear
// and the unused command code return all zeros; snapshot returns the expired
// flag, the active flag and the union of the slots still live.
// Clear, rejected adds and adds that find a free slot go straight from decode
// to the result; snapshot and an add that merges into a full table first
// scan all slots, and the merging add then writes back. The scan reads
// one slot per cycle through the single read port of the slot memory, and
// commands are processed one at a time, so a new command is taken once the
// previous one has reached the result register.
// Reset clears every active flag and the sequencer; the table is empty.
// A stalled receiver holds the result register; one further command is
// processed meanwhile and waits in the sequencer until the register frees.
module expiring_dirty_rect_tracker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,   // rect_left, rect_top, rect_right, rect_bottom, time_stamp
	input  logic [1:0]   s_tuser,   // cmd
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata    // expired_any, has_active, out_left, out_top,
	                                // out_right, out_bottom, 6 zero pad bits
);
	import edrt_pkg::*;

	slot_t                 cmd_slot;
	result_t               res;
	logic                  res_valid;
	logic                  res_ready;
	mem_req_t              req;
	slot_t                 rd_data;
	logic [SLOT_COUNT-1:0] act;
	result_t               out_q;
	logic                  out_valid_q;

	// unpack the input payload, left edge in the lowest bits
	assign cmd_slot.left   = s_tdata[31:0];
	assign cmd_slot.top    = s_tdata[63:32];
	assign cmd_slot.right  = s_tdata[95:64];
	assign cmd_slot.bottom = s_tdata[127:96];
	assign cmd_slot.expiry = s_tdata[191:128];

	edrt_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.cmd       (s_tuser),
		.cmd_slot  (cmd_slot),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.req       (req),
		.rd_data   (rd_data),
		.act       (act)
	);

	edrt_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data),
		.act     (act)
	);

	// output register: loads when empty or when its transaction completes
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_q};

endmodule
